[rtl/assert_macros.svh]
// Assertion helpers; clk and rst come from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TSWE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TSWE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tswe_pkg.sv]
package tswe_pkg;

  localparam int TICK_COUNT_BITS_DEF   = 8;
  localparam int LEADER_COUNT_BITS_DEF = 14;
  localparam int PARAM_MAX_BITS        = 16;

  localparam int KIND_BITS         = 2;
  localparam int DATA_BITS         = 8;
  localparam int LEADER_FIELD_BITS = 14;
  localparam int CFG_WIDTH         = 8;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int BYTE_BITS         = 8;
  localparam int BIT_COUNT_BITS    = 4;
  localparam int SYM_BITS          = 2;
  localparam int MODE_BITS         = 2;

  localparam logic [KIND_BITS-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_BYTE   = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_LEADER = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_FINISH = 2'd3;

  localparam logic [SYM_BITS-1:0] SYM_NONE  = 2'd0;
  localparam logic [SYM_BITS-1:0] SYM_ZERO  = 2'd1;
  localparam logic [SYM_BITS-1:0] SYM_ONE   = 2'd2;
  localparam logic [SYM_BITS-1:0] SYM_SPACE = 2'd3;

  localparam logic [MODE_BITS-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_BYTE   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_LEADER = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_FINISH = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPACE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ONE   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ZERO  = 2'd2;

  localparam logic [CFG_WIDTH-1:0] SPACE_HALF_RESET = 8'd224;
  localparam logic [CFG_WIDTH-1:0] ONE_HALF_RESET   = 8'd117;
  localparam logic [CFG_WIDTH-1:0] ZERO_HALF_RESET  = 8'd64;

  typedef struct packed {
    logic [KIND_BITS-1:0]         kind;
    logic [DATA_BITS-1:0]         data_byte;
    logic [LEADER_FIELD_BITS-1:0] leader_count;
  } cmd_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic rejected;
  } res_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] space_half_ticks;
    logic [CFG_WIDTH-1:0] one_half_ticks;
    logic [CFG_WIDTH-1:0] zero_half_ticks;
  } cfg_t;

endpackage

[rtl/tswe_if.sv]
interface tswe_cmd_if;
  logic                                  valid;
  logic                                  ready;
  logic [tswe_pkg::KIND_BITS-1:0]         kind;
  logic [tswe_pkg::DATA_BITS-1:0]         data_byte;
  logic [tswe_pkg::LEADER_FIELD_BITS-1:0] leader_count;

  modport source (output valid, kind, data_byte, leader_count, input ready);
  modport sink (input valid, kind, data_byte, leader_count, output ready);
endinterface

interface tswe_res_if;
  logic valid;
  logic ready;
  logic pin_level;
  logic busy_res;
  logic rejected;

  modport source (output valid, pin_level, busy_res, rejected, input ready);
  modport sink (input valid, pin_level, busy_res, rejected, output ready);
endinterface

interface tswe_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tswe_pkg::CFG_INDEX_BITS-1:0] index;
  logic [tswe_pkg::CFG_WIDTH-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/tswe_cfg_regs.sv]
module tswe_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  tswe_cfg_if.sink        cfg,
  output tswe_pkg::cfg_t  half_cfg
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_cfg.space_half_ticks <= tswe_pkg::SPACE_HALF_RESET;
      half_cfg.one_half_ticks   <= tswe_pkg::ONE_HALF_RESET;
      half_cfg.zero_half_ticks  <= tswe_pkg::ZERO_HALF_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        tswe_pkg::CFG_SPACE: half_cfg.space_half_ticks <= cfg.data;
        tswe_pkg::CFG_ONE:   half_cfg.one_half_ticks   <= cfg.data;
        tswe_pkg::CFG_ZERO:  half_cfg.zero_half_ticks  <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/tswe_seq.sv]
module tswe_seq #(
  parameter int TICK_COUNT_BITS   = tswe_pkg::TICK_COUNT_BITS_DEF,
  parameter int LEADER_COUNT_BITS = tswe_pkg::LEADER_COUNT_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  tswe_pkg::cmd_t item,
  input  tswe_pkg::cfg_t half_cfg,
  output tswe_pkg::res_t result
);

  logic                                  pin_reg, pin_reg_next;
  logic                                  in_second_half, in_second_half_next;
  logic [TICK_COUNT_BITS-1:0]            tick_countdown, tick_countdown_next;
  logic [tswe_pkg::SYM_BITS-1:0]         current_symbol, current_symbol_next;
  logic [tswe_pkg::BYTE_BITS-1:0]        shift_bits, shift_bits_next;
  logic [tswe_pkg::BIT_COUNT_BITS-1:0]   bits_left, bits_left_next;
  logic [LEADER_COUNT_BITS-1:0]          leader_left, leader_left_next;
  logic [tswe_pkg::MODE_BITS-1:0]        sequence_mode, sequence_mode_next;
  logic                                  hold_high_after, hold_high_after_next;

  logic                                  start_en;
  logic [tswe_pkg::SYM_BITS-1:0]         start_sym;
  logic [tswe_pkg::SYM_BITS-1:0]         half_sym;
  logic [tswe_pkg::CFG_WIDTH-1:0]        half_raw;
  logic [tswe_pkg::PARAM_MAX_BITS-1:0]   half_ext;
  logic [TICK_COUNT_BITS-1:0]            half_ticks;
  logic [tswe_pkg::PARAM_MAX_BITS-1:0]   count_ext;
  logic [LEADER_COUNT_BITS-1:0]          count;
  logic                                  rej;

  assign half_sym = start_en ? start_sym : current_symbol;

  always_comb begin
    case (half_sym)
      tswe_pkg::SYM_SPACE: half_raw = half_cfg.space_half_ticks;
      tswe_pkg::SYM_ONE:   half_raw = half_cfg.one_half_ticks;
      default:             half_raw = half_cfg.zero_half_ticks;
    endcase
  end

  assign half_ext   = tswe_pkg::PARAM_MAX_BITS'(half_raw);
  assign half_ticks = half_ext[TICK_COUNT_BITS-1:0];
  assign count_ext  = tswe_pkg::PARAM_MAX_BITS'(item.leader_count);
  assign count      = count_ext[LEADER_COUNT_BITS-1:0];

  always_comb begin
    pin_reg_next         = pin_reg;
    in_second_half_next  = in_second_half;
    tick_countdown_next  = tick_countdown;
    current_symbol_next  = current_symbol;
    shift_bits_next      = shift_bits;
    bits_left_next       = bits_left;
    leader_left_next     = leader_left;
    sequence_mode_next   = sequence_mode;
    hold_high_after_next = hold_high_after;
    start_en             = 1'b0;
    start_sym            = tswe_pkg::SYM_NONE;
    rej                  = 1'b0;

    if (item.kind == tswe_pkg::KIND_TICK) begin
      if (sequence_mode != tswe_pkg::MODE_IDLE) begin
        if (tick_countdown != '0) begin
          tick_countdown_next = tick_countdown - TICK_COUNT_BITS'(1);
        end else if (!in_second_half) begin
          pin_reg_next        = 1'b0;
          in_second_half_next = 1'b1;
          tick_countdown_next = half_ticks;
        end else if (current_symbol == tswe_pkg::SYM_SPACE) begin
          sequence_mode_next  = tswe_pkg::MODE_IDLE;
          current_symbol_next = tswe_pkg::SYM_NONE;
          in_second_half_next = 1'b0;
          tick_countdown_next = '0;
          if (hold_high_after) begin
            pin_reg_next         = 1'b1;
            hold_high_after_next = 1'b0;
          end
        end else if (sequence_mode == tswe_pkg::MODE_BYTE && bits_left != '0) begin
          start_en        = 1'b1;
          start_sym       = shift_bits[0] ? tswe_pkg::SYM_ONE : tswe_pkg::SYM_ZERO;
          shift_bits_next = shift_bits >> 1;
          bits_left_next  = bits_left - tswe_pkg::BIT_COUNT_BITS'(1);
        end else if (sequence_mode == tswe_pkg::MODE_LEADER && leader_left != '0) begin
          leader_left_next = leader_left - LEADER_COUNT_BITS'(1);
          start_en         = 1'b1;
          start_sym        = tswe_pkg::SYM_ONE;
        end else begin
          start_en  = 1'b1;
          start_sym = tswe_pkg::SYM_SPACE;
        end
      end
    end else if (sequence_mode != tswe_pkg::MODE_IDLE) begin
      rej = 1'b1;
    end else begin
      start_en = 1'b1;
      case (item.kind)
        tswe_pkg::KIND_BYTE: begin
          sequence_mode_next = tswe_pkg::MODE_BYTE;
          start_sym          = item.data_byte[0] ? tswe_pkg::SYM_ONE : tswe_pkg::SYM_ZERO;
          shift_bits_next    = item.data_byte >> 1;
          bits_left_next     = tswe_pkg::BIT_COUNT_BITS'(tswe_pkg::BYTE_BITS - 1);
        end
        tswe_pkg::KIND_LEADER: begin
          sequence_mode_next = tswe_pkg::MODE_LEADER;
          if (count == '0) begin
            leader_left_next = '0;
            start_sym        = tswe_pkg::SYM_SPACE;
          end else begin
            leader_left_next = count - LEADER_COUNT_BITS'(1);
            start_sym        = tswe_pkg::SYM_ONE;
          end
        end
        default: begin
          sequence_mode_next   = tswe_pkg::MODE_FINISH;
          hold_high_after_next = 1'b1;
          start_sym            = tswe_pkg::SYM_SPACE;
        end
      endcase
    end

    if (start_en) begin
      current_symbol_next = start_sym;
      pin_reg_next        = 1'b1;
      in_second_half_next = 1'b0;
      tick_countdown_next = half_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_reg         <= 1'b0;
      in_second_half  <= 1'b0;
      tick_countdown  <= '0;
      current_symbol  <= tswe_pkg::SYM_NONE;
      shift_bits      <= '0;
      bits_left       <= '0;
      leader_left     <= '0;
      sequence_mode   <= tswe_pkg::MODE_IDLE;
      hold_high_after <= 1'b0;
    end else if (step) begin
      pin_reg         <= pin_reg_next;
      in_second_half  <= in_second_half_next;
      tick_countdown  <= tick_countdown_next;
      current_symbol  <= current_symbol_next;
      shift_bits      <= shift_bits_next;
      bits_left       <= bits_left_next;
      leader_left     <= leader_left_next;
      sequence_mode   <= sequence_mode_next;
      hold_high_after <= hold_high_after_next;
    end
  end

  assign result.pin_level = pin_reg_next;
  assign result.busy_res  = (sequence_mode_next != tswe_pkg::MODE_IDLE);
  assign result.rejected  = rej;

endmodule

[rtl/tape_square_wave_byte_encoder_top.sv]
// Cassette square-wave encoder: each command or tick transaction yields exactly one result
// transaction with the pin level, busy flag and rejected flag after that item. A new item is
// taken every cycle unless res.ready holds the result back; its result goes from the input
// register through the combinational sequencer update into the result register. The symbol
// half-period register writes are always accepted and apply from the next half-period start.
`include "assert_macros.svh"

module tape_square_wave_byte_encoder_top #(
  parameter int TICK_COUNT_BITS   = tswe_pkg::TICK_COUNT_BITS_DEF,
  parameter int LEADER_COUNT_BITS = tswe_pkg::LEADER_COUNT_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  tswe_cmd_if.sink   cmd,
  tswe_res_if.source res,
  tswe_cfg_if.sink   cfg
);

  tswe_pkg::cfg_t half_cfg;
  tswe_pkg::cmd_t in_item;
  tswe_pkg::res_t result;
  tswe_pkg::res_t res_data;
  logic           in_valid;
  logic           res_valid;
  logic           advance;
  logic           step;

  assign advance   = !res_valid || res.ready;
  assign step      = in_valid && advance;
  assign cmd.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_item.kind         <= cmd.kind;
      in_item.data_byte    <= cmd.data_byte;
      in_item.leader_count <= cmd.leader_count;
    end
  end

  tswe_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .half_cfg (half_cfg)
  );

  tswe_seq #(
    .TICK_COUNT_BITS   (TICK_COUNT_BITS),
    .LEADER_COUNT_BITS (LEADER_COUNT_BITS)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .item     (in_item),
    .half_cfg (half_cfg),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_data <= result;
    end
  end

  assign res.valid     = res_valid;
  assign res.pin_level = res_data.pin_level;
  assign res.busy_res  = res_data.busy_res;
  assign res.rejected  = res_data.rejected;

  `TSWE_ASSERT_SAME(a_reject_busy, res_valid && res_data.rejected, res_data.busy_res, "rejected while idle")
  `TSWE_ASSERT_NEXT(a_in_hold, in_valid && !advance, in_valid && $stable(in_item), "stalled item lost")
  `TSWE_ASSERT_NEXT(a_step_res, step, res_valid, "stepped item produced no result")

endmodule
